>>> design/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and codes for the signed integer alu: operation and error
// codes, sequencer states, multiply targets and divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package sia_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_POW = 4'd4,
    OP_NEG = 4'd5,
    OP_POS = 4'd6,
    OP_MOD = 4'd7,
    OP_AND = 4'd8,
    OP_OR  = 4'd9,
    OP_XOR = 4'd10,
    OP_NOT = 4'd11,
    OP_SHL = 4'd12,
    OP_SHR = 4'd13
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_DIV0    = 2'd1,
    ERR_INVALID = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MLL,
    S_MLH,
    S_MHL,
    S_MACC,
    S_PCHK,
    S_DIV,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MT_PROD,
    MT_ACC,
    MT_BASE
  } mtgt_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> design/signed_integer_alu_top.sv
// Simple operations pass through S_EXEC and S_FINISH to the output register;
// multiply steps through S_MLL, S_MLH, S_MHL and S_MACC; divide and remainder
// by a nonzero divisor wait on the serial divider; power runs a multiply and an
// S_PCHK check per exponent bit set and per squaring, on the shared half-width
// multiplier. Throughput: one item at a time; the next transfer is taken once
// the result moves to the output register. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// signed_integer_alu_top
// Sequenced signed integer alu: logic and shift operations in S_EXEC, a shared
// multiplier for multiply and power by squaring, a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_alu_top #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_op,
  input  wire logic [63:0] in_lhs,
  input  wire logic [63:0] in_rhs,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_value,
  output logic [1:0]       out_error
);

  localparam int HW = (DATA_WIDTH + 1) / 2;
  localparam int PW = 2 * HW;
  localparam int SW = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] ONE     = (DATA_WIDTH)'(1);
  localparam logic [DATA_WIDTH-1:0] WID_VAL = (DATA_WIDTH)'(DATA_WIDTH);

  sia_pkg::state_t       state_r, state_nxt;
  sia_pkg::op_t          op_r, op_nxt;
  sia_pkg::mtgt_t        tgt_r, tgt_nxt;
  sia_pkg::err_t         err_r, err_nxt;
  sia_pkg::err_t         out_error_r, out_error_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [DATA_WIDTH-1:0] mx_r, mx_nxt;
  logic [DATA_WIDTH-1:0] my_r, my_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] base_r, base_nxt;
  logic [DATA_WIDTH-1:0] exp_r, exp_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [63:0]           out_value_r, out_value_nxt;

  logic                  accept;
  logic                  out_load;
  logic                  big_cnt;
  logic [SW-1:0]         sh_amt;
  logic [PW-1:0]         mxp, myp;
  logic [HW-1:0]         mul_a, mul_b;
  logic [PW-1:0]         mul_p;
  logic [PW-1:0]         prod_sum;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] a_mag, b_mag;
  logic [DATA_WIDTH-1:0] quo, rem;
  sia_pkg::div_stat_t    div_stat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != sia_pkg::S_IDLE);
  assign out_load = !out_valid_r || !out_stall;

  assign big_cnt = b_r[DATA_WIDTH-1] || (b_r >= WID_VAL);
  assign sh_amt  = b_r[SW-1:0];

  assign mxp   = (PW)'(mx_r);
  assign myp   = (PW)'(my_r);
  assign mul_a = (state_r == sia_pkg::S_MHL) ? mxp[PW-1:HW] : mxp[HW-1:0];
  assign mul_b = (state_r == sia_pkg::S_MLH) ? myp[PW-1:HW] : myp[HW-1:0];
  assign prod_sum = prod_r + (mul_p << HW);

  assign a_mag = a_r[DATA_WIDTH-1] ? (DATA_WIDTH)'(0) - a_r : a_r;
  assign b_mag = b_r[DATA_WIDTH-1] ? (DATA_WIDTH)'(0) - b_r : b_r;

  sia_mul_unit #(
    .HW (HW)
  ) u_mul (
    .clk  (clk),
    .opa  (mul_a),
    .opb  (mul_b),
    .prod (mul_p)
  );

  sia_div_unit #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (a_mag),
    .divisor   (b_mag),
    .quotient  (quo),
    .remainder (rem),
    .stat      (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sia_pkg::S_IDLE: begin
        if (accept) state_nxt = sia_pkg::S_EXEC;
      end
      sia_pkg::S_EXEC: begin
        state_nxt = sia_pkg::S_FINISH;
        if (op_r == sia_pkg::OP_MUL) begin
          state_nxt = sia_pkg::S_MLL;
        end else if ((op_r == sia_pkg::OP_DIV || op_r == sia_pkg::OP_MOD) && b_r != '0) begin
          state_nxt = sia_pkg::S_DIV;
        end else if (op_r == sia_pkg::OP_POW && !b_r[DATA_WIDTH-1]) begin
          state_nxt = sia_pkg::S_PCHK;
        end
      end
      sia_pkg::S_MLL: state_nxt = sia_pkg::S_MLH;
      sia_pkg::S_MLH: state_nxt = sia_pkg::S_MHL;
      sia_pkg::S_MHL: state_nxt = sia_pkg::S_MACC;
      sia_pkg::S_MACC: begin
        state_nxt = (tgt_r == sia_pkg::MT_PROD) ? sia_pkg::S_FINISH : sia_pkg::S_PCHK;
      end
      sia_pkg::S_PCHK: begin
        state_nxt = (exp_r == '0) ? sia_pkg::S_FINISH : sia_pkg::S_MLL;
      end
      sia_pkg::S_DIV: begin
        if (div_stat.done) state_nxt = sia_pkg::S_FINISH;
      end
      sia_pkg::S_FINISH: begin
        if (out_load) state_nxt = sia_pkg::S_IDLE;
      end
      default: state_nxt = sia_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt        = op_r;
    tgt_nxt       = tgt_r;
    err_nxt       = err_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_error_nxt = out_error_r;
    unique case (state_r)
      sia_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt = sia_pkg::op_t'(in_op);
          a_nxt  = in_lhs[DATA_WIDTH-1:0];
          b_nxt  = in_rhs[DATA_WIDTH-1:0];
        end
      end
      sia_pkg::S_EXEC: begin
        err_nxt = sia_pkg::ERR_OK;
        res_nxt = '0;
        unique case (op_r)
          sia_pkg::OP_ADD: res_nxt = a_r + b_r;
          sia_pkg::OP_SUB: res_nxt = a_r - b_r;
          sia_pkg::OP_NEG: res_nxt = (DATA_WIDTH)'(0) - b_r;
          sia_pkg::OP_POS: res_nxt = b_r;
          sia_pkg::OP_AND: res_nxt = a_r & b_r;
          sia_pkg::OP_OR:  res_nxt = a_r | b_r;
          sia_pkg::OP_XOR: res_nxt = a_r ^ b_r;
          sia_pkg::OP_NOT: res_nxt = {b_r[DATA_WIDTH-1], ~b_r[DATA_WIDTH-2:0]};
          sia_pkg::OP_SHL: res_nxt = big_cnt ? '0 : (a_r << sh_amt);
          sia_pkg::OP_SHR: begin
            res_nxt = big_cnt ? {DATA_WIDTH{a_r[DATA_WIDTH-1]}}
                              : DATA_WIDTH'($signed(a_r) >>> sh_amt);
          end
          sia_pkg::OP_MUL: begin
            mx_nxt  = a_r;
            my_nxt  = b_r;
            tgt_nxt = sia_pkg::MT_PROD;
          end
          sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
            if (b_r == '0) err_nxt = sia_pkg::ERR_DIV0;
            else div_start = 1'b1;
          end
          sia_pkg::OP_POW: begin
            if (b_r[DATA_WIDTH-1]) begin
              if (a_r == ONE) res_nxt = ONE;
              else if (a_r == '1) res_nxt = b_r[0] ? '1 : ONE;
              else if (a_r == '0) err_nxt = sia_pkg::ERR_DIV0;
            end else begin
              acc_nxt  = ONE;
              base_nxt = a_r;
              exp_nxt  = b_r;
            end
          end
          default: err_nxt = sia_pkg::ERR_INVALID;
        endcase
      end
      sia_pkg::S_MLL: ;
      sia_pkg::S_MLH: prod_nxt = mul_p;
      sia_pkg::S_MHL: prod_nxt = prod_sum;
      sia_pkg::S_MACC: begin
        unique case (tgt_r)
          sia_pkg::MT_ACC: begin
            acc_nxt = prod_sum[DATA_WIDTH-1:0];
            exp_nxt = {exp_r[DATA_WIDTH-1:1], 1'b0};
          end
          sia_pkg::MT_BASE: begin
            base_nxt = prod_sum[DATA_WIDTH-1:0];
            exp_nxt  = exp_r >> 1;
          end
          default: res_nxt = prod_sum[DATA_WIDTH-1:0];
        endcase
      end
      sia_pkg::S_PCHK: begin
        if (exp_r == '0) begin
          res_nxt = acc_r;
        end else if (exp_r[0]) begin
          mx_nxt  = acc_r;
          my_nxt  = base_r;
          tgt_nxt = sia_pkg::MT_ACC;
        end else begin
          mx_nxt  = base_r;
          my_nxt  = base_r;
          tgt_nxt = sia_pkg::MT_BASE;
        end
      end
      sia_pkg::S_DIV: begin
        if (div_stat.done) begin
          if (op_r == sia_pkg::OP_DIV) begin
            res_nxt = (a_r[DATA_WIDTH-1] != b_r[DATA_WIDTH-1])
                      ? (DATA_WIDTH)'(0) - quo : quo;
          end else begin
            res_nxt = a_r[DATA_WIDTH-1] ? (DATA_WIDTH)'(0) - rem : rem;
          end
        end
      end
      sia_pkg::S_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = 64'($signed(res_r));
          out_error_nxt = err_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sia_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    tgt_r       <= tgt_nxt;
    err_r       <= err_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    mx_r        <= mx_nxt;
    my_r        <= my_nxt;
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    exp_r       <= exp_nxt;
    res_r       <= res_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_error_r != sia_pkg::ERR_OK) |-> out_value_r == '0)
    else $error("error result carries a nonzero value");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == sia_pkg::S_EXEC)
    else $error("transfer not followed by execute");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sia_pkg::S_DIV |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy && !div_stat.done)
    else $error("divider started while in use");

endmodule

`default_nettype wire

>>> design/sia_mul_unit.sv
// ----------------------------------------------------------------------------
// sia_mul_unit
// Registered half-width unsigned multiplier, shared by multiply and power.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_mul_unit #(
  parameter int HW = 32
) (
  input  wire logic            clk,
  input  wire logic [HW-1:0]   opa,
  input  wire logic [HW-1:0]   opb,
  output logic      [2*HW-1:0] prod
);

  logic [2*HW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= (2*HW)'(opa) * (2*HW)'(opb);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

>>> design/sia_div_unit.sv
// ----------------------------------------------------------------------------
// sia_div_unit
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_div_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic      [DATA_WIDTH-1:0] quotient,
  output logic      [DATA_WIDTH-1:0] remainder,
  output sia_pkg::div_stat_t         stat
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;

  assign rem_sh = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = (CW)'(DATA_WIDTH);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[DATA_WIDTH]) begin
        rem_nxt = diff[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - (CW)'(1);
      if (cnt_r == (CW)'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

>>> tb/sv/tb_signed_integer_alu_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_integer_alu_top
// Self-checking bench for the signed integer alu. A short table of corner
// cases runs first, then random operations, with idle and stall bursts on
// both channels. Each result transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_signed_integer_alu_top;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int NUM_RANDOM     = 1925;
  localparam int QUIET_ITEMS    = 200;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 600;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [3:0] OP_RESERVED_LO = 4'd14;
  localparam logic [3:0] OP_RESERVED_HI = 4'd15;

  localparam logic [63:0] MIN64  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ONES64 = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] NEG3   = 64'hffff_ffff_ffff_fffd;
  localparam logic [63:0] NEG4   = 64'hffff_ffff_ffff_fffc;
  localparam logic [63:0] NEG7   = 64'hffff_ffff_ffff_fff9;

  localparam bit PRED  = 1'b0;
  localparam bit TYPED = 1'b1;

  typedef struct packed {
    logic [63:0]   value;
    sia_pkg::err_t error;
  } alu_out_t;

  typedef struct {
    logic [3:0]    op;
    logic [63:0]   lhs;
    logic [63:0]   rhs;
    bit            typed;
    logic [63:0]   value;
    sia_pkg::err_t error;
  } alu_vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_op = '0;
  logic [63:0] in_lhs = '0;
  logic [63:0] in_rhs = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_value;
  logic [1:0]  out_error;

  alu_out_t pending_results[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       quiet = 1'b0;
  bit       hold_off_req = 1'b0;

  signed_integer_alu_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_lhs    (in_lhs),
    .in_rhs    (in_rhs),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_error (out_error)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic alu_out_t alu_result(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    alu_out_t    r;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] base;
    logic [63:0] ex;
    logic [63:0] acc;
    logic        count_out;
    r.value   = '0;
    r.error   = sia_pkg::ERR_OK;
    count_out = b[63] || (b >= 64'd64);
    ua        = a[63] ? -a : a;
    ub        = b[63] ? -b : b;
    case (op)
      sia_pkg::OP_ADD: r.value = a + b;
      sia_pkg::OP_SUB: r.value = a - b;
      sia_pkg::OP_MUL: r.value = a * b;
      sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
        if (b == '0) begin
          r.error = sia_pkg::ERR_DIV0;
        end else if (op == sia_pkg::OP_DIV) begin
          r.value = ua / ub;
          if (a[63] != b[63]) r.value = -r.value;
        end else begin
          r.value = ua % ub;
          if (a[63]) r.value = -r.value;
        end
      end
      sia_pkg::OP_POW: begin
        if (b[63]) begin
          if (a == 64'd1) r.value = 64'd1;
          else if (a == ONES64) r.value = b[0] ? ONES64 : 64'd1;
          else if (a == '0) r.error = sia_pkg::ERR_DIV0;
        end else begin
          acc  = 64'd1;
          base = a;
          ex   = b;
          while (ex != '0) begin
            if (ex[0]) acc = acc * base;
            base = base * base;
            ex   = ex >> 1;
          end
          r.value = acc;
        end
      end
      sia_pkg::OP_NEG: r.value = -b;
      sia_pkg::OP_POS: r.value = b;
      sia_pkg::OP_AND: r.value = a & b;
      sia_pkg::OP_OR:  r.value = a | b;
      sia_pkg::OP_XOR: r.value = a ^ b;
      sia_pkg::OP_NOT: r.value = b ^ MAX64;
      sia_pkg::OP_SHL: r.value = count_out ? '0 : (a << b[5:0]);
      sia_pkg::OP_SHR: begin
        if (count_out) r.value = {64{a[63]}};
        else r.value = $signed(a) >>> b[5:0];
      end
      default: r.error = sia_pkg::ERR_INVALID;
    endcase
    if (r.error != sia_pkg::ERR_OK) r.value = '0;
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] t;
    case ($urandom_range(0, 9))
      0: t = MIN64;
      1: t = MAX64;
      2: t = '0;
      3: t = 64'd1;
      4: t = ONES64;
      5, 6: begin
        t = 64'($urandom_range(0, 40));
        t = t - 64'd20;
      end
      7: t = 64'd1 << $urandom_range(0, 63);
      default: t = {$urandom, $urandom};
    endcase
    return t;
  endfunction

  task automatic offer(input logic [3:0] op, input logic [63:0] a, input logic [63:0] b,
                       input bit typed, input logic [63:0] want_value,
                       input sia_pkg::err_t want_error);
    alu_out_t want;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_lhs   <= a;
    in_rhs   <= b;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      want.value = want_value;
      want.error = want_error;
    end else begin
      want = alu_result(op, a, b);
    end
    pending_results.push_back(want);
  endtask

  // receiver stall bursts and the long hold-off
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    alu_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("unexpected result transfer: value %h error %0d", out_value, out_error);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) begin
          mismatches++;
          $error("value: expected %h, got %h", want.value, out_value);
        end
        if (out_error !== want.error) begin
          mismatches++;
          $error("error: expected %0d, got %0d", want.error, out_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    alu_vec_t    directed_ops[$];
    logic [3:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] t;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_ops.push_back('{sia_pkg::OP_ADD, MAX64, 64'd1, TYPED, MIN64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_SUB, MIN64, 64'd1, TYPED, MAX64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_MUL, MIN64, ONES64, TYPED, MIN64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_DIV, MIN64, ONES64, TYPED, MIN64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_MOD, MIN64, ONES64, TYPED, 64'd0, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_DIV, 64'd7, 64'd0, TYPED, 64'd0, sia_pkg::ERR_DIV0});
    directed_ops.push_back('{sia_pkg::OP_MOD, NEG7, 64'd0, TYPED, 64'd0, sia_pkg::ERR_DIV0});
    directed_ops.push_back('{sia_pkg::OP_DIV, NEG7, 64'd2, TYPED, NEG3, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_MOD, NEG7, 64'd2, TYPED, ONES64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_POW, 64'd0, 64'd0, TYPED, 64'd1, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_POW, 64'd0, ONES64, TYPED, 64'd0, sia_pkg::ERR_DIV0});
    directed_ops.push_back('{sia_pkg::OP_POW, 64'd1, MIN64, TYPED, 64'd1, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_POW, ONES64, NEG3, TYPED, ONES64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_POW, ONES64, NEG4, TYPED, 64'd1, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_POW, 64'd2, ONES64, TYPED, 64'd0, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_POW, 64'd3, 64'd40, PRED, 64'd0, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_NEG, 64'd0, MIN64, TYPED, MIN64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_POS, 64'd0, MAX64, TYPED, MAX64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_AND, 64'haaaa_5555_f0f0_0f0f, ONES64, PRED,
                             64'd0, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_OR, 64'haaaa_5555_f0f0_0f0f, MIN64, PRED,
                             64'd0, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_XOR, 64'haaaa_5555_f0f0_0f0f, ONES64, PRED,
                             64'd0, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_NOT, 64'd0, 64'd0, TYPED, MAX64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_SHL, 64'd1, 64'd63, TYPED, MIN64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_SHL, 64'd1, 64'd64, TYPED, 64'd0, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_SHR, MIN64, 64'd64, TYPED, ONES64, sia_pkg::ERR_OK});
    directed_ops.push_back('{sia_pkg::OP_SHR, MAX64, ONES64, TYPED, 64'd0, sia_pkg::ERR_OK});
    directed_ops.push_back('{OP_RESERVED_LO, MAX64, 64'd1, TYPED, 64'd0,
                             sia_pkg::ERR_INVALID});
    directed_ops.push_back('{OP_RESERVED_HI, ONES64, ONES64, TYPED, 64'd0,
                             sia_pkg::ERR_INVALID});

    foreach (directed_ops[i]) begin
      offer(directed_ops[i].op, directed_ops[i].lhs, directed_ops[i].rhs,
            directed_ops[i].typed, directed_ops[i].value, directed_ops[i].error);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) hold_off_req = 1'b1;
      if (n == 2 * NUM_RANDOM / 3) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      if (n == NUM_RANDOM - QUIET_ITEMS) quiet = 1'b1;

      op = 4'($urandom_range(0, 13));
      if ($urandom_range(0, 24) == 0) begin
        op = 4'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      end
      a = rand_word();
      b = rand_word();
      case (op)
        sia_pkg::OP_POW: begin
          if ($urandom_range(0, 1) == 0) begin
            t = 64'($urandom_range(0, 6));
            a = t - 64'd3;
          end
          if ($urandom_range(0, 3) != 0) b = 64'($urandom_range(0, 24));
        end
        sia_pkg::OP_SHL, sia_pkg::OP_SHR: begin
          if ($urandom_range(0, 4) != 0) b = 64'($urandom_range(0, 63));
          else if ($urandom_range(0, 1) == 0) b = 64'($urandom_range(64, 70));
        end
        default: ;
      endcase
      offer(op, a, b, PRED, '0, sia_pkg::ERR_OK);
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sia_pkg.sv
design/sia_mul_unit.sv
design/sia_div_unit.sv
design/signed_integer_alu_top.sv
tb/sv/tb_signed_integer_alu_top.sv
